FILE: rtl/cvr_pkg.sv
// Shared types and constants for the cylindrical flux rotation block.
package cvr_pkg;

    // Field widths
    localparam int DATA_WIDTH      = 24;
    localparam int GROUP_W         = 32;
    localparam int CORDIC_STAGES_D = 16;

    // Position carries sign, negation and CORDIC growth headroom
    localparam int POS_W  = DATA_WIDTH + 3;
    // Unit vector and sine/cosine: signed Q30 with headroom
    localparam int UNIT_W = 33;
    localparam int UFRAC  = 30;

    localparam logic signed [UNIT_W-1:0] KINV     = 33'sd652032874;
    localparam logic signed [UNIT_W-1:0] UNIT_ONE = 33'sd1073741824;
    localparam logic [GROUP_W-1:0]       MASK_RESET = 32'h0000_0001;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] pos_x;
        logic signed [DATA_WIDTH-1:0] pos_y;
        logic signed [DATA_WIDTH-1:0] flux_x;
        logic signed [DATA_WIDTH-1:0] flux_y;
        logic signed [DATA_WIDTH-1:0] flux_z;
        logic [GROUP_W-1:0]           group_bits;
    } cvr_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] flux_radial;
        logic signed [DATA_WIDTH-1:0] flux_tangential;
        logic signed [DATA_WIDTH-1:0] flux_axial;
    } cvr_out_t;

    // Word handed from cell to cell along the CORDIC chain
    typedef struct packed {
        logic signed [POS_W-1:0]      px;
        logic signed [POS_W-1:0]      py;
        logic signed [UNIT_W-1:0]     ux;
        logic signed [UNIT_W-1:0]     uy;
        logic signed [DATA_WIDTH-1:0] fx;
        logic signed [DATA_WIDTH-1:0] fy;
        logic signed [DATA_WIDTH-1:0] fz;
        logic                         origin;
        logic                         in_group;
    } cvr_cell_t;

endpackage

FILE: rtl/cylindrical_vector_rotation.sv
// Top level: per-particle flux rotation into radial, tangential and axial parts.
//
//   channel | ports                       | moves
//   --------+-----------------------------+-----------------------------------
//   input   | s_valid s_ready s_data      | one particle word (cvr_in_t)
//   result  | m_valid m_ready m_data      | one rotated flux word (cvr_out_t)
//   config  | cfg_valid cfg_ready cfg_data| group select mask, always ready
//
// One word per cycle sustained while m_ready holds; the path is registered in the
// input register, the chain of CORDIC cells and three multiply/round/add stages.
// Reset clears every valid bit and loads the group mask with 1.
// A stall on m_ready fills the empty stages first: each stage holds only
// while the stage after it is full, so s_ready drops only when all are full.
module cylindrical_vector_rotation import cvr_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_D
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cvr_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cvr_out_t           m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [GROUP_W-1:0] cfg_data
);

    logic [GROUP_W-1:0]      mask_reg;
    logic                    valid [CORDIC_STAGES+1];
    logic                    ready [CORDIC_STAGES+1];
    cvr_cell_t               data  [CORDIC_STAGES+1];
    logic                    prep_valid_reg;
    cvr_cell_t               prep_reg;
    cvr_cell_t               prep_next;
    logic                    x_neg;
    logic signed [POS_W-1:0] x_ext, y_ext;

    // Group mask register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= MASK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            mask_reg <= cfg_data;
        end
    end

    // Fold the left half-plane by a half turn; flag origin and membership
    assign x_neg = s_data.pos_x[DATA_WIDTH-1];
    assign x_ext = POS_W'(s_data.pos_x);
    assign y_ext = POS_W'(s_data.pos_y);

    always_comb begin
        prep_next.px       = x_neg ? -x_ext : x_ext;
        prep_next.py       = x_neg ? -y_ext : y_ext;
        prep_next.ux       = x_neg ? -KINV : KINV;
        prep_next.uy       = '0;
        prep_next.fx       = s_data.flux_x;
        prep_next.fy       = s_data.flux_y;
        prep_next.fz       = s_data.flux_z;
        prep_next.origin   = (s_data.pos_x == '0) && (s_data.pos_y == '0);
        prep_next.in_group = |(s_data.group_bits & mask_reg);
    end

    assign s_ready = !prep_valid_reg || ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (s_ready) begin
            prep_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            prep_reg <= prep_next;
        end
    end

    assign valid[0] = prep_valid_reg;
    assign data[0]  = prep_reg;

    // Chain of CORDIC cells, one micro-rotation each
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        cvr_cell #(
            .STAGE (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (valid[g]),
            .up_ready (ready[g]),
            .up_data  (data[g]),
            .dn_valid (valid[g+1]),
            .dn_ready (ready[g+1]),
            .dn_data  (data[g+1])
        );
    end

    // Apply the rotation to the flux
    cvr_rotate u_rotate (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (valid[CORDIC_STAGES]),
        .up_ready (ready[CORDIC_STAGES]),
        .up_data  (data[CORDIC_STAGES]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

FILE: rtl/cvr_cell.sv
// One CORDIC vectoring cell: a micro-rotation of position and unit vector.
module cvr_cell import cvr_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      up_valid,
    output logic      up_ready,
    input  cvr_cell_t up_data,
    output logic      dn_valid,
    input  logic      dn_ready,
    output cvr_cell_t dn_data
);

    logic      valid_reg;
    cvr_cell_t data_reg;
    cvr_cell_t data_next;

    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [UNIT_W-1:0] ux;
    logic signed [UNIT_W-1:0] uy;

    // Take a word when empty or when the word held moves on
    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    assign px = up_data.px;
    assign py = up_data.py;
    assign ux = up_data.ux;
    assign uy = up_data.uy;

    // Rotate toward the x axis, steered by the sign of py
    always_comb begin
        data_next = up_data;
        if (!py[POS_W-1]) begin
            data_next.px = px + (py >>> STAGE);
            data_next.py = py - (px >>> STAGE);
            data_next.ux = ux + (uy >>> STAGE);
            data_next.uy = uy - (ux >>> STAGE);
        end else begin
            data_next.px = px - (py >>> STAGE);
            data_next.py = py + (px >>> STAGE);
            data_next.ux = ux - (uy >>> STAGE);
            data_next.uy = uy + (ux >>> STAGE);
        end
    end

    // Hold valid until the next cell takes the word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/cvr_rotate.sv
// Flux rotation by the CORDIC sine and cosine: multiply, round, add, saturate.
module cvr_rotate import cvr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      up_valid,
    output logic      up_ready,
    input  cvr_cell_t up_data,
    output logic      m_valid,
    input  logic      m_ready,
    output cvr_out_t  m_data
);

    localparam int LO_W   = 16;
    localparam int HI_W   = UNIT_W - LO_W;
    localparam int PART_W = DATA_WIDTH + HI_W;
    localparam int PROD_W = DATA_WIDTH + UNIT_W + 1;
    localparam int RND_W  = PROD_W - UFRAC;
    localparam int SUM_W  = RND_W + 1;

    localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(1) <<< (UFRAC - 1);
    localparam logic signed [SUM_W-1:0]  SAT_HI = (SUM_W'(1) <<< (DATA_WIDTH - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0]  SAT_LO = -SAT_HI - SUM_W'(1);

    function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_WIDTH-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[DATA_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[DATA_WIDTH-1:0];
        end else begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // Product order: fx*c, fy*s, fy*c, fx*s
    logic signed [DATA_WIDTH-1:0] fac_f [4];
    logic signed [UNIT_W-1:0]     fac_k [4];
    logic signed [UNIT_W-1:0]     cos_v;
    logic signed [UNIT_W-1:0]     sin_v;

    logic                         a_valid_reg, b_valid_reg, c_valid_reg;
    logic                         a_ready, b_ready, c_ready;
    logic signed [PART_W-1:0]     hi_reg [4];
    logic signed [PART_W-1:0]     hi_next [4];
    logic signed [PART_W-1:0]     lo_reg [4];
    logic signed [PART_W-1:0]     lo_next [4];
    logic signed [RND_W-1:0]      rnd_reg [4];
    logic signed [RND_W-1:0]      rnd_next [4];
    logic signed [PROD_W-1:0]     prod [4];
    logic signed [DATA_WIDTH-1:0] a_fz_reg, b_fz_reg;
    logic                         a_grp_reg, b_grp_reg;
    logic signed [SUM_W-1:0]      sum_r, sum_t;
    cvr_out_t                     out_reg, out_next;

    // Each stage advances when empty or when its word moves on
    assign c_ready  = !c_valid_reg || m_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;
    assign m_valid  = c_valid_reg;
    assign m_data   = out_reg;

    // Pick cosine and sine; the origin keeps the flux unrotated
    always_comb begin
        cos_v = up_data.origin ? UNIT_ONE : up_data.ux;
        sin_v = up_data.origin ? '0 : -up_data.uy;
        fac_f[0] = up_data.fx;  fac_k[0] = cos_v;
        fac_f[1] = up_data.fy;  fac_k[1] = sin_v;
        fac_f[2] = up_data.fy;  fac_k[2] = cos_v;
        fac_f[3] = up_data.fx;  fac_k[3] = sin_v;
        for (int k = 0; k < 4; k++) begin
            hi_next[k] = PART_W'(fac_f[k]) * PART_W'($signed(fac_k[k][UNIT_W-1:LO_W]));
            lo_next[k] = PART_W'(fac_f[k]) * PART_W'($signed({1'b0, fac_k[k][LO_W-1:0]}));
        end
    end

    // Recombine partial products and round half up
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k]     = (PROD_W'(hi_reg[k]) <<< LO_W) + PROD_W'(lo_reg[k]) + HALF;
            rnd_next[k] = prod[k][PROD_W-1:UFRAC];
        end
    end

    // Add the rounded products and saturate; drop non-members to zero
    always_comb begin
        sum_r = SUM_W'(rnd_reg[0]) + SUM_W'(rnd_reg[1]);
        sum_t = SUM_W'(rnd_reg[2]) - SUM_W'(rnd_reg[3]);
        out_next = '0;
        if (b_grp_reg) begin
            out_next.flux_radial     = sat(sum_r);
            out_next.flux_tangential = sat(sum_t);
            out_next.flux_axial      = b_fz_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= up_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && up_valid) begin
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            a_fz_reg  <= up_data.fz;
            a_grp_reg <= up_data.in_group;
        end
        if (b_ready && a_valid_reg) begin
            rnd_reg   <= rnd_next;
            b_fz_reg  <= a_fz_reg;
            b_grp_reg <= a_grp_reg;
        end
        if (c_ready && b_valid_reg) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: rtl/cvr_checker.sv
// Port-level checks for the flux rotation block, bound to the top level.
module cvr_checker import cvr_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_D
) (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input cvr_out_t m_data
);

    localparam int DEPTH = CORDIC_STAGES + 4;
    localparam int CNT_W = $clog2(DEPTH + 1) + 1;

    logic [CNT_W-1:0] count_reg;
    logic             in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // Track words inside the block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (in_acc && !out_acc) begin
            count_reg <= count_reg + CNT_W'(1);
        end else if (out_acc && !in_acc) begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> count_reg != '0)
        else $error("result word without an input word");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> s_ready)
        else $error("empty block refuses input");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("more words inside than pipeline stages");

endmodule

bind cylindrical_vector_rotation cvr_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_cvr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
